[rtl/imp_pkg.sv]
// Shared types, opcodes and cycle costs for the instruction mix profiler.
package imp_pkg;

  localparam int unsigned INSTR_W       = 32;
  localparam int unsigned OUT_W         = 48;
  localparam int unsigned CNT_W_DEFAULT = 48;
  localparam int unsigned REG_W         = 6;
  localparam int unsigned CYC_W         = 6;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_TRAP    = 6'h1a;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // function codes under OP_SPECIAL
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  // trap codes
  localparam logic [3:0] TR_PLAIN  = 4'h0;
  localparam logic [3:0] TR_PRINT  = 4'h1;
  localparam logic [3:0] TR_PROMPT = 4'h5;
  localparam logic [3:0] TR_STOP   = 4'ha;

  // register codes
  localparam logic [REG_W-1:0] REG_ZERO  = 6'd0;
  localparam logic [REG_W-1:0] REG_RA    = 6'd31;
  localparam logic [REG_W-1:0] HILO_CODE = 6'd32;

  // cycle costs
  localparam logic [CYC_W-1:0] CYC_ALU    = 6'd1;
  localparam logic [CYC_W-1:0] CYC_SHIFT  = 6'd2;
  localparam logic [CYC_W-1:0] CYC_JUMP   = 6'd2;
  localparam logic [CYC_W-1:0] CYC_MOVE   = 6'd3;
  localparam logic [CYC_W-1:0] CYC_TRAP   = 6'd3;
  localparam logic [CYC_W-1:0] CYC_MEM    = 6'd8;
  localparam logic [CYC_W-1:0] CYC_MULDIV = 6'd32;
  localparam logic [CYC_W-1:0] BR_PENALTY = 6'd2;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_R,
    CLS_I,
    CLS_J
  } cls_t;

  // one decoded word as it travels from front to back
  typedef struct packed {
    logic             rd1_en;
    logic [REG_W-1:0] rd1;
    logic             rd2_en;
    logic [REG_W-1:0] rd2;
    logic [REG_W-1:0] wr;
    cls_t             cls;
    logic [CYC_W-1:0] cyc;
    logic             unk;
    logic             halt;
  } dec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/imp_if.sv]
// Handshake channels: instruction words in, running totals out.
interface imp_in_if import imp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INSTR_W-1:0] instr_word;
  logic               branch_taken;

  modport source (output valid, output instr_word, output branch_taken, input ready);
  modport sink   (input valid, input instr_word, input branch_taken, output ready);
endinterface

interface imp_out_if import imp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] instr_total;
  logic [OUT_W-1:0] r_type_total;
  logic [OUT_W-1:0] i_type_total;
  logic [OUT_W-1:0] j_type_total;
  logic [OUT_W-1:0] zero_read_total;
  logic [OUT_W-1:0] cycle_total;
  logic [OUT_W-1:0] dep_one_total;
  logic [OUT_W-1:0] dep_two_total;
  logic [OUT_W-1:0] dep_three_total;
  logic             unimplemented;
  logic             halt;

  modport source (
    output valid, output instr_total, output r_type_total, output i_type_total,
    output j_type_total, output zero_read_total, output cycle_total,
    output dep_one_total, output dep_two_total, output dep_three_total,
    output unimplemented, output halt, input ready
  );
  modport sink (
    input valid, input instr_total, input r_type_total, input i_type_total,
    input j_type_total, input zero_read_total, input cycle_total,
    input dep_one_total, input dep_two_total, input dep_three_total,
    input unimplemented, input halt, output ready
  );
endinterface

[rtl/instruction_mix_dependency_profiler.sv]
// Top level of the instruction mix and dependency profiler.
//
//  channel  | dir | handshake     | word contents
//  ---------+-----+---------------+------------------------------------------------
//  in_ch    | in  | valid / ready | instr_word, branch_taken
//  out_ch   | out | valid / ready | nine running totals, unimplemented, halt
//
// Sustained rate is one word per clock in and one per clock out while out_ch.ready
// stays high. A word that is taken is first written into a decode queue slot, then
// its counts are registered in the back-end counters that show its totals.
// rst (synchronous, active high) empties the queue, zeroes every counter and
// fills the write history with register zero.
// While a result waits on out_ch the queue keeps taking words until its two
// slots are full; in_ch.ready then drops until the back end moves again.
//
// Structure: imp_front decodes and classifies each word, imp_queue holds the
// decoded entries, imp_back owns the three-entry write history, matches source
// reads against it and keeps the saturating counters that drive out_ch.
// Counters are COUNTER_WIDTH wide and are shown zero-extended or cut to 48 bits.
module instruction_mix_dependency_profiler import imp_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = CNT_W_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  imp_in_if.sink    in_ch,
  imp_out_if.source out_ch
);

  q_stat_t qstat;
  logic    push;
  logic    pop;
  dec_t    push_dec;
  dec_t    head;

  // decode: no state, ready follows queue space
  imp_front u_front (
    .in_ch    (in_ch),
    .qstat    (qstat),
    .push     (push),
    .push_dec (push_dec)
  );

  // decouples decode from counting so either side may stall
  imp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_dec (push_dec),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // the counter registers themselves are the result word
  imp_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

[rtl/imp_front.sv]
// Front end: takes instruction words and decodes them into queue entries.
module imp_front import imp_pkg::*; (
  imp_in_if.sink   in_ch,
  input  q_stat_t  qstat,
  output logic     push,
  output dec_t     push_dec
);

  logic [5:0] op;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [4:0] rd;
  logic [5:0] fn;
  logic [3:0] tc;

  assign op = in_ch.instr_word[31:26];
  assign rs = in_ch.instr_word[25:21];
  assign rt = in_ch.instr_word[20:16];
  assign rd = in_ch.instr_word[15:11];
  assign fn = in_ch.instr_word[5:0];
  assign tc = in_ch.instr_word[3:0];

  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && !qstat.full;

  always_comb begin
    push_dec     = '0;
    push_dec.cls = CLS_NONE;
    case (op)
      OP_SPECIAL: begin
        push_dec.cls = CLS_R;
        case (fn)
          FN_SLL, FN_SRA: begin
            push_dec.rd1_en = 1'b1;
            push_dec.rd1    = {1'b0, rs};
            push_dec.wr     = {1'b0, rd};
            push_dec.cyc    = CYC_SHIFT;
          end
          FN_JR: begin
            push_dec.rd1_en = 1'b1;
            push_dec.rd1    = {1'b0, rs};
            push_dec.cyc    = CYC_JUMP;
          end
          FN_MFHI, FN_MFLO: begin
            push_dec.rd1_en = 1'b1;
            push_dec.rd1    = HILO_CODE;
            push_dec.wr     = {1'b0, rd};
            push_dec.cyc    = CYC_MOVE;
          end
          FN_MULT, FN_DIV: begin
            push_dec.rd1_en = 1'b1;
            push_dec.rd1    = {1'b0, rs};
            push_dec.rd2_en = 1'b1;
            push_dec.rd2    = {1'b0, rt};
            push_dec.wr     = HILO_CODE;
            push_dec.cyc    = CYC_MULDIV;
          end
          FN_ADDU, FN_SUBU, FN_SLT: begin
            push_dec.rd1_en = 1'b1;
            push_dec.rd1    = {1'b0, rs};
            push_dec.rd2_en = 1'b1;
            push_dec.rd2    = {1'b0, rt};
            push_dec.wr     = {1'b0, rd};
            push_dec.cyc    = CYC_ALU;
          end
          default: push_dec.unk = 1'b1;
        endcase
      end
      OP_J: begin
        push_dec.cls = CLS_J;
        push_dec.cyc = CYC_JUMP;
      end
      OP_JAL: begin
        push_dec.cls = CLS_J;
        push_dec.cyc = CYC_JUMP;
        push_dec.wr  = REG_RA;
      end
      OP_BEQ, OP_BNE: begin
        push_dec.cls    = CLS_I;
        push_dec.rd1_en = 1'b1;
        push_dec.rd1    = {1'b0, rs};
        push_dec.rd2_en = 1'b1;
        push_dec.rd2    = {1'b0, rt};
        push_dec.cyc    = in_ch.branch_taken ? (CYC_ALU + BR_PENALTY) : CYC_ALU;
      end
      OP_ADDIU, OP_ANDI, OP_LW: begin
        push_dec.cls    = CLS_I;
        push_dec.rd1_en = 1'b1;
        push_dec.rd1    = {1'b0, rs};
        push_dec.wr     = {1'b0, rt};
        push_dec.cyc    = (op == OP_LW) ? CYC_MEM : CYC_ALU;
      end
      OP_LUI: begin
        push_dec.cls = CLS_I;
        push_dec.wr  = {1'b0, rt};
        push_dec.cyc = CYC_ALU;
      end
      OP_SW: begin
        push_dec.cls    = CLS_I;
        push_dec.rd1_en = 1'b1;
        push_dec.rd1    = {1'b0, rs};
        push_dec.rd2_en = 1'b1;
        push_dec.rd2    = {1'b0, rt};
        push_dec.cyc    = CYC_MEM;
      end
      OP_TRAP: begin
        push_dec.cls = CLS_J;
        push_dec.cyc = CYC_TRAP;
        case (tc)
          TR_PLAIN: ;
          TR_PRINT: begin
            push_dec.rd1_en = 1'b1;
            push_dec.rd1    = {1'b0, rs};
          end
          TR_PROMPT: push_dec.wr   = {1'b0, rt};
          TR_STOP:   push_dec.halt = 1'b1;
          default:   push_dec.unk  = 1'b1;
        endcase
      end
      default: push_dec.unk = 1'b1;
    endcase

    // unknown words only bump the instruction count and shift in no write
    if (push_dec.unk) begin
      push_dec.cls    = CLS_NONE;
      push_dec.rd1_en = 1'b0;
      push_dec.rd2_en = 1'b0;
      push_dec.wr     = REG_ZERO;
      push_dec.cyc    = '0;
      push_dec.halt   = 1'b0;
    end
  end

endmodule

[rtl/imp_queue.sv]
// Short queue of decoded words between front and back.
module imp_queue import imp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  dec_t    push_dec,
  input  logic    pop,
  output dec_t    head,
  output q_stat_t qstat
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  dec_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/imp_back.sv]
// Back end: write history, dependency matching and saturating totals.
module imp_back import imp_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = CNT_W_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  q_stat_t  qstat,
  input  dec_t     head,
  output logic     pop,
  imp_out_if.source out_ch
);

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  function automatic cnt_t sat_add(input cnt_t c, input cnt_t inc);
    logic [COUNTER_WIDTH:0] s;
    s = {1'b0, c} + {1'b0, inc};
    return s[COUNTER_WIDTH] ? '1 : s[COUNTER_WIDTH-1:0];
  endfunction

  logic [REG_W-1:0] hist [3];
  cnt_t instr_cnt, r_cnt, i_cnt, j_cnt, zero_cnt, cyc_cnt;
  cnt_t dep_cnt [3];
  logic out_valid;
  logic unk_q;
  logic halt_q;

  logic [1:0]       rd_en;
  logic [REG_W-1:0] rd_reg [2];
  logic [1:0]       zero_hit;
  logic [1:0]       dep_hit [3];
  logic [1:0]       zero_inc;
  logic [1:0]       dep_inc [3];

  assign pop = !qstat.empty && (!out_valid || out_ch.ready);

  assign rd_en     = {head.rd2_en, head.rd1_en};
  assign rd_reg[0] = head.rd1;
  assign rd_reg[1] = head.rd2;

  // each read goes to the newest matching history slot; zero never matches
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      zero_hit[i]   = rd_en[i] && (rd_reg[i] == REG_ZERO);
      dep_hit[0][i] = rd_en[i] && !zero_hit[i] && (rd_reg[i] == hist[0]);
      dep_hit[1][i] = rd_en[i] && !zero_hit[i] && !dep_hit[0][i]
                      && (rd_reg[i] == hist[1]);
      dep_hit[2][i] = rd_en[i] && !zero_hit[i] && !dep_hit[0][i] && !dep_hit[1][i]
                      && (rd_reg[i] == hist[2]);
    end
    zero_inc = {1'b0, zero_hit[0]} + {1'b0, zero_hit[1]};
    for (int k = 0; k < 3; k++) begin
      dep_inc[k] = {1'b0, dep_hit[k][0]} + {1'b0, dep_hit[k][1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      unk_q     <= 1'b0;
      halt_q    <= 1'b0;
      instr_cnt <= '0;
      r_cnt     <= '0;
      i_cnt     <= '0;
      j_cnt     <= '0;
      zero_cnt  <= '0;
      cyc_cnt   <= '0;
      for (int k = 0; k < 3; k++) begin
        hist[k]    <= REG_ZERO;
        dep_cnt[k] <= '0;
      end
    end else if (pop) begin
      out_valid <= 1'b1;
      unk_q     <= head.unk;
      halt_q    <= head.halt;
      instr_cnt <= sat_add(instr_cnt, cnt_t'(1));
      r_cnt     <= sat_add(r_cnt, cnt_t'(head.cls == CLS_R));
      i_cnt     <= sat_add(i_cnt, cnt_t'(head.cls == CLS_I));
      j_cnt     <= sat_add(j_cnt, cnt_t'(head.cls == CLS_J));
      zero_cnt  <= sat_add(zero_cnt, cnt_t'(zero_inc));
      cyc_cnt   <= sat_add(cyc_cnt, cnt_t'(head.cyc));
      for (int k = 0; k < 3; k++) begin
        dep_cnt[k] <= sat_add(dep_cnt[k], cnt_t'(dep_inc[k]));
      end
      hist[0] <= head.wr;
      hist[1] <= hist[0];
      hist[2] <= hist[1];
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.instr_total     = OUT_W'(instr_cnt);
  assign out_ch.r_type_total    = OUT_W'(r_cnt);
  assign out_ch.i_type_total    = OUT_W'(i_cnt);
  assign out_ch.j_type_total    = OUT_W'(j_cnt);
  assign out_ch.zero_read_total = OUT_W'(zero_cnt);
  assign out_ch.cycle_total     = OUT_W'(cyc_cnt);
  assign out_ch.dep_one_total   = OUT_W'(dep_cnt[0]);
  assign out_ch.dep_two_total   = OUT_W'(dep_cnt[1]);
  assign out_ch.dep_three_total = OUT_W'(dep_cnt[2]);
  assign out_ch.unimplemented   = unk_q;
  assign out_ch.halt            = halt_q;

endmodule

[rtl/imp_checker.sv]
// Port-level checks for the profiler, bound to the top level.
module imp_checker import imp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] instr_total,
  input logic             unimplemented,
  input logic             halt
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // a STOP trap is always a known instruction
  a_halt_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(halt && unimplemented))
    else $error("halt and unimplemented raised together");

  // instruction count never falls from one word to the next
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (instr_total >= $past(instr_total)))
    else $error("instruction total went down");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(instr_total)))
    else $error("stalled result word changed");

endmodule

bind instruction_mix_dependency_profiler imp_checker u_imp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .instr_total   (out_ch.instr_total),
  .unimplemented (out_ch.unimplemented),
  .halt          (out_ch.halt)
);
